FILE: rtl/vvq_pkg.sv
// ----------------------------------------------------------------------------
// vvq_pkg: velocity vector quantizer shared types
// beat formats, chain stage formats, constants and small helper functions
// ----------------------------------------------------------------------------
package vvq_pkg;

   localparam int unsigned SQRT_CELLS = 24;
   localparam int unsigned DIV_CELLS  = 24;

   localparam logic       CMD_ENCODE = 1'b0;
   localparam logic       CMD_DECODE = 1'b1;

   localparam logic [23:0] MAX_SPEED_RESET = 24'd25600;
   localparam logic [10:0] SPEED_MAX_CODE  = 11'd2047;
   localparam logic [8:0]  AXIS_MAX_CODE   = 9'd511;
   localparam logic [23:0] MIN_SPEED       = 24'd3;
   localparam logic [23:0] OUT_MAG_MAX     = 24'h7FFFFF;

   typedef struct packed {
      logic               cmd;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic signed [23:0] vel_z;
      logic [31:0]        packed_in;
   } req_beat_type;

   typedef struct packed {
      logic [31:0]        packed_out;
      logic signed [23:0] out_x;
      logic signed [23:0] out_y;
      logic signed [23:0] out_z;
   } rsp_beat_type;

   // sideband carried through the root chain
   typedef struct packed {
      logic        cmd;
      logic [2:0]  neg;
      logic        zero;
      logic [34:0] n0;
      logic [23:0] a0;
      logic [23:0] a1;
   } side_type;

   typedef struct packed {
      logic        vld;
      logic [47:0] rad;
      logic [25:0] rem;
      logic [23:0] root;
      side_type    side;
   } sqrt_type;

   typedef struct packed {
      logic [23:0] bits;
      logic [23:0] rem;
      logic [23:0] den;
      logic [23:0] quo;
      logic        sat;
   } lane_type;

   typedef struct packed {
      logic                vld;
      logic                cmd;
      logic [2:0]          neg;
      logic                zero;
      logic [16:0]         ux;
      logic [16:0]         uy;
      logic [16:0]         uz;
      lane_type [2:0]      lane;
   } div_type;

   function automatic logic [23:0] mag24(input logic [23:0] v);
      return v[23] ? (~v + 24'd1) : v;
   endfunction

   // floor(f * 65536 / 511)
   function automatic logic [16:0] unit_of(input logic [8:0] f);
      logic [15:0] t;
      logic [6:0]  q0;
      logic [16:0] r;
      t  = {f, 7'b0};
      q0 = t[15:9];
      r  = 17'(t) - 17'({q0, 9'b0}) + 17'(q0);
      return 17'(t) + 17'(q0) + ((r >= 17'd511) ? 17'd1 : 17'd0);
   endfunction

   function automatic lane_type lane_init(input logic [34:0] num, input logic [23:0] den);
      lane_type l;
      l.bits = num[23:0];
      l.rem  = 24'(num[34:24]);
      l.den  = den;
      l.quo  = '0;
      l.sat  = (24'(num[34:24]) >= den);
      return l;
   endfunction

endpackage

FILE: rtl/vvq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vvq_sqrt_cell: one cell of the integer square root chain
// retires two radicand bits and one root bit per cell
// ----------------------------------------------------------------------------
module vvq_sqrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  vvq_pkg::sqrt_type  cell_in,
   output vvq_pkg::sqrt_type  cell_out
);

   vvq_pkg::sqrt_type stage_ff;
   vvq_pkg::sqrt_type stage_in;
   logic [27:0]       cur;
   logic [27:0]       trial;

   always_comb begin
      stage_in = cell_in;
      cur      = {cell_in.rem, cell_in.rad[47:46]};
      trial    = {2'b0, cell_in.root, 2'b01};
      if (cur >= trial) begin
         stage_in.rem  = 26'(cur - trial);
         stage_in.root = {cell_in.root[22:0], 1'b1};
      end else begin
         stage_in.rem  = cur[25:0];
         stage_in.root = {cell_in.root[22:0], 1'b0};
      end
      stage_in.rad = {cell_in.rad[45:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else if (en) begin
         stage_ff.vld <= stage_in.vld;
      end
      if (en) begin
         stage_ff.rad  <= stage_in.rad;
         stage_ff.rem  <= stage_in.rem;
         stage_ff.root <= stage_in.root;
         stage_ff.side <= stage_in.side;
      end
   end

   assign cell_out = stage_ff;

endmodule

FILE: rtl/vvq_div_cell.sv
// ----------------------------------------------------------------------------
// vvq_div_cell: one cell of the three-lane restoring divider chain
// each lane retires one quotient bit per cell
// ----------------------------------------------------------------------------
module vvq_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  vvq_pkg::div_type  cell_in,
   output vvq_pkg::div_type  cell_out
);

   vvq_pkg::div_type stage_ff;
   vvq_pkg::div_type stage_in;
   logic [24:0]      cur [3];

   always_comb begin
      stage_in = cell_in;
      for (int i = 0; i < 3; i++) begin
         cur[i] = {cell_in.lane[i].rem, cell_in.lane[i].bits[23]};
         if (cur[i] >= {1'b0, cell_in.lane[i].den}) begin
            stage_in.lane[i].rem = 24'(cur[i] - {1'b0, cell_in.lane[i].den});
            stage_in.lane[i].quo = {cell_in.lane[i].quo[22:0], 1'b1};
         end else begin
            stage_in.lane[i].rem = cur[i][23:0];
            stage_in.lane[i].quo = {cell_in.lane[i].quo[22:0], 1'b0};
         end
         stage_in.lane[i].bits = {cell_in.lane[i].bits[22:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else if (en) begin
         stage_ff.vld <= stage_in.vld;
      end
      if (en) begin
         stage_ff.cmd  <= stage_in.cmd;
         stage_ff.neg  <= stage_in.neg;
         stage_ff.zero <= stage_in.zero;
         stage_ff.ux   <= stage_in.ux;
         stage_ff.uy   <= stage_in.uy;
         stage_ff.uz   <= stage_in.uz;
         stage_ff.lane <= stage_in.lane;
      end
   end

   assign cell_out = stage_ff;

endmodule

FILE: rtl/velocity_vector_quantizer.sv
// ----------------------------------------------------------------------------
// velocity_vector_quantizer: 3d velocity to 32-bit word codec
// encode packs signs, quantized speed and two unit parts; decode unpacks them
//
//   channel  direction  beat            handshake
//   req      in         req_beat_type   req_valid / req_stall
//   rsp      out        rsp_beat_type   rsp_valid / rsp_stall
//   csr      in         max_speed       csr_write_en / csr_write_data
//
// one beat per cycle sustained while the skid register stays empty; each beat
// passes through 54 register stages in all, ending at the output register:
// 3 front stages, the 24-cell root chain, the divider setup
// stage, the 24-cell divider chain, the back stage and the output register
// reset is synchronous and empties the pipeline; max_speed returns to 25600
// rsp_stall fills the skid register after the output register, and only a
// full skid register raises req_stall and holds the whole chain
// ----------------------------------------------------------------------------
module velocity_vector_quantizer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  vvq_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output vvq_pkg::rsp_beat_type rsp_beat,
   input  logic                  csr_write_en,
   input  logic [23:0]           csr_write_data
);

   logic [23:0] max_speed_ff;

   logic        en;
   logic        skid_vld_ff;
   logic        skid_vld_in;
   logic        rsp_vld_ff;
   logic        rsp_vld_in;
   vvq_pkg::rsp_beat_type rsp_ff, rsp_in;
   vvq_pkg::rsp_beat_type skid_ff, skid_in;

   logic                  f1_vld_ff;
   vvq_pkg::req_beat_type f1_ff;
   logic                  f2_vld_ff;
   vvq_pkg::side_type     f2_side_ff, f2_side_in;
   logic [23:0]           f2_a2_ff, f2_a2_in;
   logic                  f3_vld_ff;
   vvq_pkg::side_type     f3_side_ff;
   logic [2:0][47:0]      f3_sq_ff, f3_sq_in;

   vvq_pkg::sqrt_type     sq_chain [vvq_pkg::SQRT_CELLS + 1];
   vvq_pkg::div_type      dv_chain [vvq_pkg::DIV_CELLS + 1];
   vvq_pkg::div_type      d0_ff, d0_in;

   logic                  b1_vld_ff;
   logic                  b1_cmd_ff;
   logic                  b1_zero_ff;
   logic [2:0]            b1_neg_ff;
   logic [31:0]           b1_word_ff, b1_word_in;
   logic [2:0][40:0]      b1_prod_ff, b1_prod_in;

   logic [47:0]           sum_sq;
   logic [23:0]           root;
   logic [10:0]           sc;
   logic [8:0]            fx, fy;
   logic [24:0]           m [3];
   logic [23:0]           mag [3];
   logic [23:0]           part [3];
   vvq_pkg::rsp_beat_type new_beat;
   logic                  last_move;
   logic                  rsp_take;

   assign en        = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= vvq_pkg::MAX_SPEED_RESET;
      end else if (csr_write_en) begin
         max_speed_ff <= csr_write_data;
      end
   end

   // front: magnitudes and unit parts
   always_comb begin
      f2_side_in = '0;
      f2_a2_in   = '0;
      if (f1_ff.cmd == vvq_pkg::CMD_ENCODE) begin
         f2_side_in.cmd = vvq_pkg::CMD_ENCODE;
         f2_side_in.neg = {f1_ff.vel_x[23], f1_ff.vel_y[23], f1_ff.vel_z[23]};
         f2_side_in.a0  = vvq_pkg::mag24(f1_ff.vel_x);
         f2_side_in.a1  = vvq_pkg::mag24(f1_ff.vel_y);
         f2_a2_in       = vvq_pkg::mag24(f1_ff.vel_z);
      end else begin
         f2_side_in.cmd  = vvq_pkg::CMD_DECODE;
         f2_side_in.neg  = f1_ff.packed_in[31:29];
         f2_side_in.zero = (f1_ff.packed_in == 32'd0);
         f2_side_in.a0   = 24'(vvq_pkg::unit_of(f1_ff.packed_in[17:9]));
         f2_side_in.a1   = 24'(vvq_pkg::unit_of(f1_ff.packed_in[8:0]));
         f2_side_in.n0   = 35'(f1_ff.packed_in[28:18]) * 35'(max_speed_ff);
      end
   end

   always_comb begin
      f3_sq_in[0] = 48'(f2_side_ff.a0) * 48'(f2_side_ff.a0);
      f3_sq_in[1] = 48'(f2_side_ff.a1) * 48'(f2_side_ff.a1);
      f3_sq_in[2] = 48'(f2_a2_ff) * 48'(f2_a2_ff);
   end

   always_comb begin
      sum_sq = f3_sq_ff[0] + f3_sq_ff[1] + f3_sq_ff[2];
      sq_chain[0].vld  = f3_vld_ff;
      sq_chain[0].rem  = '0;
      sq_chain[0].root = '0;
      sq_chain[0].side = f3_side_ff;
      if (f3_side_ff.cmd == vvq_pkg::CMD_ENCODE) begin
         sq_chain[0].rad = sum_sq;
      end else if (sum_sq[47:32] != 16'd0) begin
         sq_chain[0].rad = '0;
      end else begin
         sq_chain[0].rad = 48'h1_0000_0000 - sum_sq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
      end else if (en) begin
         f1_vld_ff <= req_valid;
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff      <= req_beat;
         f2_side_ff <= f2_side_in;
         f2_a2_ff   <= f2_a2_in;
         f3_side_ff <= f2_side_ff;
         f3_sq_ff   <= f3_sq_in;
      end
   end

   for (genvar i = 0; i < vvq_pkg::SQRT_CELLS; i++) begin : g_sqrt
      vvq_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (sq_chain[i]),
         .cell_out (sq_chain[i + 1])
      );
   end

   // divider setup
   always_comb begin
      root    = sq_chain[vvq_pkg::SQRT_CELLS].root;
      d0_in   = '0;
      d0_in.vld = sq_chain[vvq_pkg::SQRT_CELLS].vld;
      d0_in.cmd = sq_chain[vvq_pkg::SQRT_CELLS].side.cmd;
      d0_in.neg = sq_chain[vvq_pkg::SQRT_CELLS].side.neg;
      if (d0_in.cmd == vvq_pkg::CMD_ENCODE) begin
         d0_in.zero    = (root < vvq_pkg::MIN_SPEED);
         d0_in.lane[0] = vvq_pkg::lane_init(35'({root, 11'b0}) - 35'(root), max_speed_ff);
         d0_in.lane[1] = vvq_pkg::lane_init(
            35'({sq_chain[vvq_pkg::SQRT_CELLS].side.a0, 9'b0})
            - 35'(sq_chain[vvq_pkg::SQRT_CELLS].side.a0), root);
         d0_in.lane[2] = vvq_pkg::lane_init(
            35'({sq_chain[vvq_pkg::SQRT_CELLS].side.a1, 9'b0})
            - 35'(sq_chain[vvq_pkg::SQRT_CELLS].side.a1), root);
      end else begin
         d0_in.zero    = sq_chain[vvq_pkg::SQRT_CELLS].side.zero;
         d0_in.ux      = sq_chain[vvq_pkg::SQRT_CELLS].side.a0[16:0];
         d0_in.uy      = sq_chain[vvq_pkg::SQRT_CELLS].side.a1[16:0];
         d0_in.uz      = root[16:0];
         d0_in.lane[0] = vvq_pkg::lane_init(sq_chain[vvq_pkg::SQRT_CELLS].side.n0,
                                            24'(vvq_pkg::SPEED_MAX_CODE));
         d0_in.lane[1] = vvq_pkg::lane_init(35'd0, 24'd1);
         d0_in.lane[2] = vvq_pkg::lane_init(35'd0, 24'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_ff.vld <= 1'b0;
      end else if (en) begin
         d0_ff.vld <= d0_in.vld;
      end
      if (en) begin
         d0_ff.cmd  <= d0_in.cmd;
         d0_ff.neg  <= d0_in.neg;
         d0_ff.zero <= d0_in.zero;
         d0_ff.ux   <= d0_in.ux;
         d0_ff.uy   <= d0_in.uy;
         d0_ff.uz   <= d0_in.uz;
         d0_ff.lane <= d0_in.lane;
      end
   end

   assign dv_chain[0] = d0_ff;

   for (genvar i = 0; i < vvq_pkg::DIV_CELLS; i++) begin : g_div
      vvq_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (dv_chain[i]),
         .cell_out (dv_chain[i + 1])
      );
   end

   // back: word assembly and speed scaling
   always_comb begin
      if (dv_chain[vvq_pkg::DIV_CELLS].lane[0].sat
          || dv_chain[vvq_pkg::DIV_CELLS].lane[0].quo > 24'(vvq_pkg::SPEED_MAX_CODE)) begin
         sc = vvq_pkg::SPEED_MAX_CODE;
      end else begin
         sc = dv_chain[vvq_pkg::DIV_CELLS].lane[0].quo[10:0];
      end
      fx = (dv_chain[vvq_pkg::DIV_CELLS].lane[1].quo > 24'(vvq_pkg::AXIS_MAX_CODE))
           ? vvq_pkg::AXIS_MAX_CODE : dv_chain[vvq_pkg::DIV_CELLS].lane[1].quo[8:0];
      fy = (dv_chain[vvq_pkg::DIV_CELLS].lane[2].quo > 24'(vvq_pkg::AXIS_MAX_CODE))
           ? vvq_pkg::AXIS_MAX_CODE : dv_chain[vvq_pkg::DIV_CELLS].lane[2].quo[8:0];
      if (dv_chain[vvq_pkg::DIV_CELLS].cmd == vvq_pkg::CMD_ENCODE
          && !dv_chain[vvq_pkg::DIV_CELLS].zero) begin
         b1_word_in = {dv_chain[vvq_pkg::DIV_CELLS].neg, sc, fx, fy};
      end else begin
         b1_word_in = '0;
      end
      b1_prod_in[0] = 41'(dv_chain[vvq_pkg::DIV_CELLS].lane[0].quo)
                      * 41'(dv_chain[vvq_pkg::DIV_CELLS].ux);
      b1_prod_in[1] = 41'(dv_chain[vvq_pkg::DIV_CELLS].lane[0].quo)
                      * 41'(dv_chain[vvq_pkg::DIV_CELLS].uy);
      b1_prod_in[2] = 41'(dv_chain[vvq_pkg::DIV_CELLS].lane[0].quo)
                      * 41'(dv_chain[vvq_pkg::DIV_CELLS].uz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
      end else if (en) begin
         b1_vld_ff <= dv_chain[vvq_pkg::DIV_CELLS].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_cmd_ff  <= dv_chain[vvq_pkg::DIV_CELLS].cmd;
         b1_zero_ff <= dv_chain[vvq_pkg::DIV_CELLS].zero;
         b1_neg_ff  <= dv_chain[vvq_pkg::DIV_CELLS].neg;
         b1_word_ff <= b1_word_in;
         b1_prod_ff <= b1_prod_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m[i]    = b1_prod_ff[i][40:16];
         mag[i]  = (m[i] > 25'(vvq_pkg::OUT_MAG_MAX)) ? vvq_pkg::OUT_MAG_MAX : m[i][23:0];
         if (b1_cmd_ff == vvq_pkg::CMD_ENCODE || b1_zero_ff) begin
            part[i] = '0;
         end else begin
            part[i] = b1_neg_ff[2 - i] ? (~mag[i] + 24'd1) : mag[i];
         end
      end
      new_beat.packed_out = b1_word_ff;
      new_beat.out_x      = part[0];
      new_beat.out_y      = part[1];
      new_beat.out_z      = part[2];
   end

   // output register with skid
   assign last_move = b1_vld_ff && en;
   assign rsp_take  = rsp_vld_ff && !rsp_stall;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_in      = rsp_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (rsp_take || !rsp_vld_ff) begin
         if (skid_vld_ff) begin
            rsp_vld_in  = 1'b1;
            rsp_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else if (last_move) begin
            rsp_vld_in = 1'b1;
            rsp_in     = new_beat;
         end else begin
            rsp_vld_in = 1'b0;
         end
      end else if (last_move) begin
         skid_vld_in = 1'b1;
         skid_in     = new_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_beat  = rsp_ff;

endmodule

FILE: rtl/vvq_checker.sv
// ----------------------------------------------------------------------------
// vvq_checker: port-level checks for the velocity vector quantizer
// watches the rsp channel and reset behavior, bound to the top level
// ----------------------------------------------------------------------------
module vvq_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input vvq_pkg::rsp_beat_type rsp_beat
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
      else $error("rsp beat changed while stalled");

   // pipeline empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // a beat carries either a word or a vector, never both
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_beat.packed_out == 32'd0)
                    || (rsp_beat.out_x == 24'sd0 && rsp_beat.out_y == 24'sd0
                        && rsp_beat.out_z == 24'sd0))
      else $error("word and vector both nonzero");

   // magnitudes saturate before the sign is applied
   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_beat.out_x != 24'h800000 && rsp_beat.out_y != 24'h800000
                    && rsp_beat.out_z != 24'h800000)
      else $error("decoded part reached the most negative code");

endmodule

bind velocity_vector_quantizer vvq_checker u_vvq_checker (.*);

FILE: test/velocity_vector_quantizer_test.sv
// ----------------------------------------------------------------------------
// velocity_vector_quantizer_test: self-checking bench for the velocity codec
// predicts every encode and decode beat in the bench, streams directed and
// random vectors and words with bursty input and patterned output stall,
// and walks max_speed through several settings between idle phases
// ----------------------------------------------------------------------------
module velocity_vector_quantizer_test;

   localparam int LATENCY     = 54;
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   vvq_pkg::req_beat_type req_beat;
   logic                  rsp_valid;
   logic                  rsp_stall;
   vvq_pkg::rsp_beat_type rsp_beat;
   logic                  csr_write_en;
   logic [23:0]           csr_write_data;

   vvq_pkg::req_beat_type pending_beats[$];
   vvq_pkg::rsp_beat_type expected_rsp[$];
   logic [23:0]  max_speed_model;
   int           mismatches;
   int           cycles;
   int           beats_sent;
   int           beats_checked;
   int           gap_left;
   int           burst_left;
   bit           traffic_on;

   velocity_vector_quantizer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_beat       (req_beat),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_beat       (rsp_beat),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] magnitude(input logic [23:0] v);
      return v[23] ? 64'(25'h1000000 - 25'(v)) : 64'(v);
   endfunction

   function automatic logic [23:0] scaled_part(input logic [63:0] sp, input logic [63:0] u,
                                               input logic neg);
      logic [63:0] m;
      m = (sp * u) >> 16;
      if (m > 64'h7FFFFF) m = 64'h7FFFFF;
      return neg ? 24'(-m) : 24'(m);
   endfunction

   function automatic vvq_pkg::rsp_beat_type codec_result(input vvq_pkg::req_beat_type b);
      vvq_pkg::rsp_beat_type r;
      logic [63:0]  ax, ay, az, s, sc, fx, fy, fs, ux, uy, uz, sq, sp;
      logic [31:0]  w;
      r = '0;
      if (b.cmd == vvq_pkg::CMD_ENCODE) begin
         ax = magnitude(b.vel_x);
         ay = magnitude(b.vel_y);
         az = magnitude(b.vel_z);
         s  = root64(ax * ax + ay * ay + az * az);
         if (s < 3) return r;
         sc = (max_speed_model == 0) ? 64'd2047 : (s * 2047) / max_speed_model;
         if (sc > 2047) sc = 2047;
         fx = (ax * 511) / s;
         fy = (ay * 511) / s;
         if (fx > 511) fx = 511;
         if (fy > 511) fy = 511;
         r.packed_out = {b.vel_x[23], b.vel_y[23], b.vel_z[23], sc[10:0], fx[8:0], fy[8:0]};
      end else begin
         w = b.packed_in;
         if (w == 0) return r;
         fx = 64'(w[17:9]);
         fy = 64'(w[8:0]);
         fs = 64'(w[28:18]);
         ux = (fx << 16) / 511;
         uy = (fy << 16) / 511;
         sq = ux * ux + uy * uy;
         uz = (sq < (64'd1 << 32)) ? root64((64'd1 << 32) - sq) : 64'd0;
         sp = (fs * max_speed_model) / 2047;
         r.out_x = scaled_part(sp, ux, w[31]);
         r.out_y = scaled_part(sp, uy, w[30]);
         r.out_z = scaled_part(sp, uz, w[29]);
      end
      return r;
   endfunction

   function automatic vvq_pkg::req_beat_type vector_beat(input logic [23:0] x,
                                                         input logic [23:0] y,
                                                         input logic [23:0] z);
      vvq_pkg::req_beat_type b;
      b = '0;
      b.cmd   = vvq_pkg::CMD_ENCODE;
      b.vel_x = x;
      b.vel_y = y;
      b.vel_z = z;
      return b;
   endfunction

   function automatic vvq_pkg::req_beat_type word_beat(input logic [31:0] w);
      vvq_pkg::req_beat_type b;
      b = '0;
      b.cmd       = vvq_pkg::CMD_DECODE;
      b.packed_in = w;
      return b;
   endfunction

   function automatic logic [23:0] random_component();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'($signed(16'($urandom)));
         2: return 24'($signed(8'($urandom)));
         default: return 24'($signed(20'($urandom)));
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_beat  <= '0;
         gap_left  <= 0;
         burst_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) beats_sent <= beats_sent + 1;
         if (pending_beats.size() != 0 && traffic_on && gap_left == 0) begin
            req_beat  <= pending_beats.pop_front();
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 20);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end
      end
   end

   // accepted beats are predicted here
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) expected_rsp.push_back(codec_result(req_beat));
   end

   // receiver stall: phases of none, light and heavy stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case ((cycles / 300) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      vvq_pkg::rsp_beat_type exp_beat;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected beat %h", rsp_beat);
         end else begin
            exp_beat = expected_rsp.pop_front();
            beats_checked <= beats_checked + 1;
            if (exp_beat.packed_out !== rsp_beat.packed_out || exp_beat.out_x !== rsp_beat.out_x
                || exp_beat.out_y !== rsp_beat.out_y || exp_beat.out_z !== rsp_beat.out_z) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected word %h xyz %h %h %h, got word %h xyz %h %h %h",
                     exp_beat.packed_out, exp_beat.out_x, exp_beat.out_y, exp_beat.out_z,
                     rsp_beat.packed_out, rsp_beat.out_x, rsp_beat.out_y, rsp_beat.out_z);
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic drain_phase();
      traffic_on = 1'b1;
      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      traffic_on = 1'b0;
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_max_speed(input logic [23:0] v);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      max_speed_model = v;
   endtask

   task automatic queue_random(input int n);
      logic [31:0] w;
      repeat (n) begin
         if ($urandom_range(0, 1) == 0) begin
            pending_beats.push_back(vector_beat(random_component(), random_component(),
                                                random_component()));
         end else begin
            w = $urandom;
            if ($urandom_range(0, 9) == 0) w = 32'(w[2:0]);
            pending_beats.push_back(word_beat(w));
         end
      end
   endtask

   initial begin
      logic [23:0] speeds[6];
      speeds = '{24'd1, 24'hFFFFFF, 24'd2047, 24'd100, 24'd7000000, 24'd0};
      reset = 1'b1;
      req_valid = 1'b0;
      req_beat = '0;
      rsp_stall = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      mismatches = 0;
      cycles = 0;
      beats_sent = 0;
      beats_checked = 0;
      traffic_on = 1'b0;
      max_speed_model = vvq_pkg::MAX_SPEED_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, tiny speeds, zero word, saturation
      pending_beats.push_back(vector_beat(24'd0, 24'd0, 24'd0));
      pending_beats.push_back(vector_beat(24'd2, 24'd0, 24'd0));
      pending_beats.push_back(vector_beat(24'd1, 24'd1, 24'd1));
      pending_beats.push_back(vector_beat(24'd3, 24'd0, 24'd0));
      pending_beats.push_back(vector_beat(-24'sd3, 24'd0, 24'd0));
      pending_beats.push_back(vector_beat(24'h800000, 24'h800000, 24'h800000));
      pending_beats.push_back(vector_beat(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
      pending_beats.push_back(vector_beat(24'h7FFFFF, 24'h800000, 24'd0));
      pending_beats.push_back(vector_beat(24'd0, 24'd0, 24'hFFFFFF));
      pending_beats.push_back(vector_beat(24'd25600, 24'd0, 24'd0));
      pending_beats.push_back(vector_beat(24'd0, -24'sd25600, 24'd0));
      pending_beats.push_back(word_beat(32'd0));
      pending_beats.push_back(word_beat(32'hFFFFFFFF));
      pending_beats.push_back(word_beat(32'h1FFC0000));
      pending_beats.push_back(word_beat({3'b111, 11'd2047, 9'd511, 9'd0}));
      pending_beats.push_back(word_beat({3'b010, 11'd1024, 9'd0, 9'd511}));
      pending_beats.push_back(word_beat({3'b001, 11'd1, 9'd0, 9'd0}));
      pending_beats.push_back(word_beat(32'h00000001));
      drain_phase();

      write_max_speed(24'hFFFFFF);
      pending_beats.push_back(word_beat({3'b100, 11'd2047, 9'd511, 9'd0}));
      pending_beats.push_back(word_beat(32'hFFFFFFFF));
      pending_beats.push_back(vector_beat(24'h7FFFFF, 24'd0, 24'd0));
      drain_phase();

      foreach (speeds[i]) begin
         write_max_speed(speeds[i]);
         queue_random(150);
         drain_phase();
      end
      write_max_speed(24'($urandom_range(1, 24'hFFFFFF)));
      queue_random(150);
      drain_phase();

      $display("sent %0d beats, checked %0d over %0d max_speed settings, %0d mismatches",
         beats_sent, beats_checked, 9, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
